@@ design/fmr_pkg.sv @@
// ----------------------------------------------------------------------------
// fmr_pkg: shared types and constants for the fraction multiply/reduce block
// Field widths, the saturation limit and the divider request/response bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmr_pkg;

  // all fraction fields are 31-bit unsigned
  localparam int unsigned FieldW  = 31;
  localparam int unsigned DivCntW = $clog2(FieldW);
  localparam int unsigned ProdW   = 2 * FieldW;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [ProdW-1:0]  prod_t;

  localparam field_t FieldMax = {FieldW{1'b1}};
  localparam field_t FieldOne = field_t'(1);

  // request into the shared divider
  typedef struct packed {
    logic   start;
    field_t dividend;
    field_t divisor;
  } fmr_div_req_t;

  // status and results out of the shared divider
  typedef struct packed {
    logic   busy;
    logic   done;
    field_t quotient;
    field_t remainder;
  } fmr_div_rsp_t;

endpackage

@@ design/fmr_div.sv @@
// ----------------------------------------------------------------------------
// fmr_div: shared iterative divider
// Restoring radix-2 divider, one quotient bit per cycle. Gives quotient and
// remainder with done, which pulses for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmr_div
  import fmr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fmr_div_req_t req_i,
  output fmr_div_rsp_t rsp_o
);

  localparam logic [DivCntW-1:0] LastCnt = DivCntW'(FieldW - 1);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  field_t             rem_q, rem_d;
  field_t             quo_q, quo_d;
  field_t             dvs_q;

  logic [FieldW:0]    shifted;
  logic [FieldW:0]    diff;
  logic               ge;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_q, quo_q[FieldW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = ge ? diff[FieldW-1:0] : shifted[FieldW-1:0];
    quo_d   = {quo_q[FieldW-2:0], ge};
  end

  // iteration control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  // partial remainder always stays below the divisor
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("divider partial remainder not below divisor");

  // done only after the last iteration, never while still busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q) && $past(cnt_q) == LastCnt)
    else $error("divider done out of sequence");

endmodule

@@ design/fmr_mul.sv @@
// ----------------------------------------------------------------------------
// fmr_mul: registered multiplier with saturation
// Multiplies two 31-bit values into a registered full product, then clamps
// to the 31-bit range and flags overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmr_mul
  import fmr_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  field_t a_i,
  input  field_t b_i,
  output field_t prod_o,
  output logic   ovf_o
);

  prod_t prod_q;

  // full product register, loaded on enable
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_t'(a_i) * prod_t'(b_i);
    end
  end

  // saturate anything above the field range
  assign ovf_o  = |prod_q[ProdW-1:FieldW];
  assign prod_o = ovf_o ? FieldMax : prod_q[FieldW-1:0];

endmodule

@@ design/fraction_multiply_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_multiply_reduce: fraction product with cross-cancellation
// Multiplies a_num/a_den by b_num/b_den after dividing out
// g1 = gcd(a_num, b_den) and g2 = gcd(b_num, a_den); saturating products.
// ----------------------------------------------------------------------------
// One item at a time. All division work runs through one shared radix-2
// divider: each Euclid remainder step is a divider start and a wait for the
// result, as is each of the four cancelling divisions, and a gcd is done once
// the remainder is zero; each gcd takes at most about 45 remainder steps for
// 31-bit values. The numerator and denominator products are then formed in
// turn in the registered multiplier and moved to the output register once it
// is free. in_stall_o is high from acceptance until the result has been
// moved to the output register; a waiting result does not block the next
// item from being accepted. gcd(0,0) is taken as 1, zero denominators pass
// through, and an overflowing product reads 2^31-1 with overflow_o set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fraction_multiply_reduce
  import fmr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  field_t a_num_i,
  input  field_t a_den_i,
  input  field_t b_num_i,
  input  field_t b_den_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output field_t prod_num_o,
  output field_t prod_den_o,
  output logic   overflow_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_QUO_GO,
    ST_QUO_DIV,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_OUT
  } state_e;

  state_e       state_q;
  field_t       an_q, ad_q, bn_q, bd_q;
  field_t       p_q, q_q;
  field_t       g1_q, g2_q;
  logic         gsel_q;
  logic [1:0]   qidx_q;
  field_t       pn_q;
  logic         ovf_q;
  logic         out_valid_q;
  field_t       out_num_q, out_den_q;
  logic         out_ovf_q;

  fmr_div_req_t div_req;
  fmr_div_rsp_t div_rsp;
  logic         mul_en;
  field_t       mul_a, mul_b;
  field_t       mul_prod;
  logic         mul_ovf;
  field_t       gcd_val;
  logic         out_free;

  fmr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fmr_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod),
    .ovf_o  (mul_ovf)
  );

  // gcd result once the remainder hits zero; both zero gives one
  assign gcd_val  = (p_q == '0) ? FieldOne : p_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // divider operand select
  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_GCD_CHK: begin
        div_req.start    = q_q != '0;
        div_req.dividend = p_q;
        div_req.divisor  = q_q;
      end
      ST_QUO_GO: begin
        div_req.start = 1'b1;
        unique case (qidx_q)
          2'd0: begin
            div_req.dividend = an_q;
            div_req.divisor  = g1_q;
          end
          2'd1: begin
            div_req.dividend = bd_q;
            div_req.divisor  = g1_q;
          end
          2'd2: begin
            div_req.dividend = bn_q;
            div_req.divisor  = g2_q;
          end
          default: begin
            div_req.dividend = ad_q;
            div_req.divisor  = g2_q;
          end
        endcase
      end
      default: div_req = '0;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_en = (state_q == ST_MUL_NUM) || (state_q == ST_MUL_DEN);
    mul_a  = (state_q == ST_MUL_DEN) ? ad_q : an_q;
    mul_b  = (state_q == ST_MUL_DEN) ? bd_q : bn_q;
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      an_q        <= '0;
      ad_q        <= '0;
      bn_q        <= '0;
      bd_q        <= '0;
      p_q         <= '0;
      q_q         <= '0;
      g1_q        <= FieldOne;
      g2_q        <= FieldOne;
      gsel_q      <= 1'b0;
      qidx_q      <= '0;
      pn_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_num_q   <= '0;
      out_den_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            an_q    <= a_num_i;
            ad_q    <= a_den_i;
            bn_q    <= b_num_i;
            bd_q    <= b_den_i;
            p_q     <= a_num_i;
            q_q     <= b_den_i;
            gsel_q  <= 1'b0;
            state_q <= ST_GCD_CHK;
          end
        end
        ST_GCD_CHK: begin
          if (q_q == '0) begin
            if (!gsel_q) begin
              g1_q   <= gcd_val;
              p_q    <= bn_q;
              q_q    <= ad_q;
              gsel_q <= 1'b1;
            end else begin
              g2_q    <= gcd_val;
              qidx_q  <= '0;
              state_q <= ST_QUO_GO;
            end
          end else begin
            state_q <= ST_GCD_DIV;
          end
        end
        ST_GCD_DIV: begin
          // Euclid step: (p, q) becomes (q, p mod q)
          if (div_rsp.done) begin
            p_q     <= q_q;
            q_q     <= div_rsp.remainder;
            state_q <= ST_GCD_CHK;
          end
        end
        ST_QUO_GO: begin
          state_q <= ST_QUO_DIV;
        end
        ST_QUO_DIV: begin
          if (div_rsp.done) begin
            unique case (qidx_q)
              2'd0:    an_q <= div_rsp.quotient;
              2'd1:    bd_q <= div_rsp.quotient;
              2'd2:    bn_q <= div_rsp.quotient;
              default: ad_q <= div_rsp.quotient;
            endcase
            qidx_q  <= qidx_q + 1'b1;
            state_q <= (qidx_q == 2'd3) ? ST_MUL_NUM : ST_QUO_GO;
          end
        end
        ST_MUL_NUM: begin
          state_q <= ST_MUL_DEN;
        end
        ST_MUL_DEN: begin
          pn_q    <= mul_prod;
          ovf_q   <= mul_ovf;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // result leaves the sequencer once the output slot is free, so a
      // held result does not block the next item
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        out_num_q   <= pn_q;
        out_den_q   <= mul_prod;
        out_ovf_q   <= ovf_q | mul_ovf;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign prod_num_o  = out_num_q;
  assign prod_den_o  = out_den_q;
  assign overflow_o  = out_ovf_q;

  // divider is never restarted while an operation is in flight
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // cancelling divisors are never zero
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QUO_GO |-> g1_q != '0 && g2_q != '0)
    else $error("zero gcd used as divisor");

  // overflow flag implies at least one saturated product
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> prod_num_o == FieldMax || prod_den_o == FieldMax)
    else $error("overflow without a saturated product");

  // a new result is only loaded when the previous one has left
  a_out_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && state_q == ST_OUT |=> state_q == ST_OUT || !out_stall_i
      || $past(!out_stall_i))
    else $error("result overwritten while held");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fraction_multiply_reduce
// Sends directed and random fraction pairs and compares every product with
// a predictor that runs the gcd cross-cancel and saturating multiplies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import fmr_pkg::*;
();

  localparam int unsigned RandomItems   = 280;
  localparam int unsigned MaxItemCycles = 3200;
  localparam int unsigned MaxGap        = 300;
  localparam int unsigned MaxStall      = 3000;
  localparam longint unsigned CycleLimit =
    4 * (RandomItems + 25) * (MaxItemCycles + MaxGap + MaxStall);
  localparam int unsigned DrainCycles   = 3200;

  // one expected product
  typedef struct packed {
    field_t num;
    field_t den;
    logic   ovf;
  } product_t;

  // predicts cross-cancelled products and checks them in arrival order
  class product_book;
    product_t pending[$];
    int unsigned errors;

    static function field_t gcd_euclid(field_t x, field_t y);
      while (y != '0) begin
        x = x % y;
        if (x == '0) break;
        y = y % x;
      end
      x = x + y;
      return (x == '0) ? FieldOne : x;
    endfunction

    static function field_t clamp_mul(field_t p, field_t q, ref logic ovf);
      prod_t full;
      full = prod_t'(p) * prod_t'(q);
      if (full > prod_t'(FieldMax)) begin
        ovf = 1'b1;
        return FieldMax;
      end
      return field_t'(full);
    endfunction

    function void note_operands(field_t an, field_t ad, field_t bn, field_t bd);
      field_t   g1, g2;
      product_t p;
      logic     ovf;
      g1    = gcd_euclid(an, bd);
      g2    = gcd_euclid(bn, ad);
      ovf   = 1'b0;
      p.num = clamp_mul(an / g1, bn / g2, ovf);
      p.den = clamp_mul(ad / g2, bd / g1, ovf);
      p.ovf = ovf;
      pending.push_back(p);
    endfunction

    function void check_product(field_t num, field_t den, logic ovf);
      product_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d ovf=%0b", $time, num, den, ovf);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (num !== want.num) begin
        $display("%0t: prod_num expected %0d actual %0d", $time, want.num, num);
        errors++;
      end
      if (den !== want.den) begin
        $display("%0t: prod_den expected %0d actual %0d", $time, want.den, den);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  field_t a_num_i     = '0;
  field_t a_den_i     = '0;
  field_t b_num_i     = '0;
  field_t b_den_i     = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  field_t prod_num_o;
  field_t prod_den_o;
  logic   overflow_o;

  product_book     book = new();
  longint unsigned cycles = 0;

  fraction_multiply_reduce uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prod_num_o  (prod_num_o),
    .prod_den_o  (prod_den_o),
    .overflow_o  (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      book.check_product(prod_num_o, prod_den_o, overflow_o);
    end
  end

  // idle gap before an item: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(20, MaxGap);
  endfunction

  // one field: extremes, tiny values, random widths or full random
  function automatic field_t draw_field();
    int unsigned r, w;
    r = $urandom_range(0, 9);
    w = $urandom_range(1, FieldW);
    case (r)
      0:       return FieldMax;
      1:       return field_t'($urandom_range(0, 15));
      2, 3, 4: return field_t'($urandom) & field_t'((32'd1 << w) - 1);
      default: return field_t'($urandom);
    endcase
  endfunction

  function automatic field_t fib(int unsigned k);
    field_t x, y, t;
    x = '0;
    y = FieldOne;
    repeat (k) begin
      t = x + y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // random operand set; favors shared factors and deep Euclid chains
  function automatic void draw_operands(output field_t an, output field_t ad,
                                        output field_t bn, output field_t bd);
    int unsigned mode, f1, f2, k, j;
    mode = $urandom_range(0, 9);
    f1   = $urandom_range(2, 46000);
    f2   = $urandom_range(2, 46000);
    k    = $urandom_range(2, 46);
    j    = $urandom_range(2, 46);
    an   = draw_field();
    ad   = draw_field();
    bn   = draw_field();
    bd   = draw_field();
    case (mode)
      6, 7: begin
        an = field_t'(f1 * $urandom_range(0, 46000));
        bd = field_t'(f1 * $urandom_range(0, 46000));
        bn = field_t'(f2 * $urandom_range(0, 46000));
        ad = field_t'(f2 * $urandom_range(0, 46000));
      end
      8: begin
        an = fib(k);
        bd = fib(k - 1);
        bn = fib(j);
        ad = fib(j - 1);
      end
      9: begin
        if ($urandom_range(0, 1)) an = '0;
        if ($urandom_range(0, 1)) ad = '0;
        if ($urandom_range(0, 1)) bn = '0;
        if ($urandom_range(0, 1)) bd = '0;
      end
      default: ;
    endcase
  endfunction

  // present one item after an optional gap and hold it until accepted
  task automatic offer_operands(field_t an, field_t ad, field_t bn, field_t bd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_num_i    <= an;
    a_den_i    <= ad;
    b_num_i    <= bn;
    b_den_i    <= bd;
    do @(posedge clk_i); while (in_stall_o);
    book.note_operands(an, ad, bn, bd);
  endtask

  // output back-pressure: ready stretches and stall bursts of mixed length
  initial begin : rx_pressure
    int unsigned r, run;
    forever begin
      r   = $urandom_range(0, 99);
      run = (r < 60) ? $urandom_range(1, 20) :
            (r < 90) ? $urandom_range(20, 200) : $urandom_range(300, 3000);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      r   = $urandom_range(0, 99);
      run = (r < 85) ? $urandom_range(1, 4) :
            (r < 98) ? $urandom_range(5, 60) : $urandom_range(500, MaxStall);
      out_stall_i <= 1'b1;
      repeat (run) @(posedge clk_i);
    end
  end

  // stimulus and end of run
  initial begin : main
    field_t an, ad, bn, bd;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zeros, extremes, cross-cancel, overflow edges, deep gcds
    offer_operands('0, '0, '0, '0);
    offer_operands(FieldMax, FieldMax, FieldMax, FieldMax);
    offer_operands(FieldOne, FieldOne, FieldOne, FieldOne);
    offer_operands('0, 31'd7, 31'd3, 31'd5);
    offer_operands(31'd6, 31'd9, '0, '0);
    offer_operands(31'd3, '0, '0, 31'd7);
    offer_operands(31'd6, 31'd35, 31'd14, 31'd9);
    offer_operands(FieldMax, FieldOne, 31'd2, FieldOne);
    offer_operands(FieldOne, 31'd65536, FieldOne, 31'd65536);
    offer_operands(FieldMax, FieldMax - 31'd1, FieldMax - 31'd2, FieldMax - 31'd3);
    offer_operands(31'd46341, FieldOne, 31'd46341, FieldOne);
    offer_operands(31'd46340, FieldOne, 31'd46341, FieldOne);
    offer_operands(FieldMax, FieldOne, FieldOne, FieldOne);
    offer_operands(31'd1836311903, 31'd1836311903, 31'd1134903170, 31'd1134903170);
    offer_operands(31'h55555555, 31'h2AAAAAAA, 31'h2AAAAAAA, 31'h55555555);
    offer_operands(31'h40000000, 31'h40000000, 31'h20000000, 31'h10000000);
    offer_operands(31'd12, 31'd0, 31'd0, 31'd18);
    offer_operands(FieldMax, '0, FieldMax, '0);

    // random
    repeat (RandomItems) begin
      draw_operands(an, ad, bn, bd);
      offer_operands(an, ad, bn, bd);
    end
    in_valid_i <= 1'b0;

    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
